// ===== design/tnr_pkg.sv =====
// ----------------------------------------------------------------------------
// tnr_pkg
// shared types and constants for the tchebycheff neighbor replacement block
// ----------------------------------------------------------------------------
package tnr_pkg;

  localparam int POOL_DEPTH    = 256;
  localparam int NEIGHBORS_MAX = 16;
  localparam int IDX_W         = $clog2(POOL_DEPTH);
  localparam int SLOT_W        = $clog2(NEIGHBORS_MAX);
  localparam int CNT_W         = $clog2(NEIGHBORS_MAX + 1);
  localparam int NB_DEPTH      = POOL_DEPTH * NEIGHBORS_MAX;

  localparam int OBJ_W   = 32;
  localparam int WGT_W   = 17;
  localparam int TAG_W   = 16;
  localparam int SCALE_W = 16;
  localparam int MAG_W   = OBJ_W + 1;
  localparam int PROD_W  = MAG_W + WGT_W;
  localparam int MASK_W  = 16;

  localparam logic [WGT_W-1:0] WEIGHT_ONE  = WGT_W'(65536);
  localparam logic [OBJ_W-1:0] IDEAL_RESET = 32'h7FFF_FFFF;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 88;

  typedef enum logic [1:0] {
    CMD_LOAD_ENTRY = 2'd0,
    CMD_LOAD_NBR   = 2'd1,
    CMD_OFFER      = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_NBR_COUNT = 1'b0,
    CFG_ZW_SCALE  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NBR,
    S_ENT,
    S_DIFF,
    S_MUL,
    S_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [OBJ_W-1:0] obj_first;
    logic signed [OBJ_W-1:0] obj_second;
    logic [TAG_W-1:0]        tag;
    logic [WGT_W-1:0]        weight;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  typedef struct packed {
    logic diff_en;
    logic mul_en;
  } score_ctl_t;

endpackage

// ===== design/tnr_ram.sv =====
// ----------------------------------------------------------------------------
// tnr_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module tnr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tnr_score.sv =====
// ----------------------------------------------------------------------------
// tnr_score
// weighted tchebycheff compare of a stored entry against the candidate
// ----------------------------------------------------------------------------
module tnr_score
  import tnr_pkg::*;
(
  input  logic                    clk,
  input  score_ctl_t              ctl,
  input  entry_t                  ent,
  input  logic signed [OBJ_W-1:0] cand_first,
  input  logic signed [OBJ_W-1:0] cand_second,
  input  logic signed [OBJ_W-1:0] ideal_first,
  input  logic signed [OBJ_W-1:0] ideal_second,
  input  logic [SCALE_W-1:0]      zw_scale,
  output logic                    replace
);

  logic [MAG_W-1:0]  mag_sa_r, mag_sb_r, mag_ca_r, mag_cb_r;
  logic [WGT_W-1:0]  wa_r, wb_r;
  logic [PROD_W-1:0] prod_sa_r, prod_sb_r, prod_ca_r, prod_cb_r;
  logic [WGT_W-1:0]  wb_raw;
  logic [PROD_W-1:0] score_sto, score_cand;

  function automatic logic [MAG_W-1:0] abs_gap(logic signed [OBJ_W-1:0] v,
                                              logic signed [OBJ_W-1:0] z);
    logic signed [MAG_W-1:0] d;
    d = MAG_W'(v) - MAG_W'(z);
    return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  assign wb_raw = WEIGHT_ONE - ent.weight;

  always_ff @(posedge clk) begin
    if (ctl.diff_en) begin
      mag_sa_r <= abs_gap(ent.obj_first, ideal_first);
      mag_sb_r <= abs_gap(ent.obj_second, ideal_second);
      mag_ca_r <= abs_gap(cand_first, ideal_first);
      mag_cb_r <= abs_gap(cand_second, ideal_second);
      wa_r     <= (ent.weight == '0) ? WGT_W'(zw_scale) : ent.weight;
      wb_r     <= (wb_raw == '0) ? WGT_W'(zw_scale) : wb_raw;
    end
    if (ctl.mul_en) begin
      prod_sa_r <= PROD_W'(mag_sa_r) * PROD_W'(wa_r);
      prod_sb_r <= PROD_W'(mag_sb_r) * PROD_W'(wb_r);
      prod_ca_r <= PROD_W'(mag_ca_r) * PROD_W'(wa_r);
      prod_cb_r <= PROD_W'(mag_cb_r) * PROD_W'(wb_r);
    end
  end

  assign score_sto  = (prod_sa_r > prod_sb_r) ? prod_sa_r : prod_sb_r;
  assign score_cand = (prod_ca_r > prod_cb_r) ? prod_ca_r : prod_cb_r;
  assign replace    = score_cand < score_sto;

endmodule

// ===== design/tchebycheff_neighbor_replacement.sv =====
// ----------------------------------------------------------------------------
// tchebycheff_neighbor_replacement
// two-objective pool with neighborhood replacement by weighted tchebycheff score
// ----------------------------------------------------------------------------
// Pool entries and neighbor lists live in two block rams; neither is cleared
// at reset, so every entry and neighbor slot must be loaded before an offer
// reads it. Load and unused commands give their result on the next cycle. An
// offer updates the ideal point when it is accepted, then walks the neighbor
// list one slot at a time: read entry, take gaps, multiply, compare and write
// back, over the entry memory's single read port. The walk covers n slots
// (neighbor_count, held to sixteen); when n is zero an offer goes straight to
// its result. One transaction is worked on at a time; a new one is taken in the
// cycle its predecessor's result is taken or while the output is empty.
// ----------------------------------------------------------------------------
module tchebycheff_neighbor_replacement
  import tnr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // cmd, index, slot, neighbor, obj_first, obj_second, weight_first, tag
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // done_cmd, replaced_mask, replaced_count, ideal_first, ideal_second
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [SCALE_W-1:0]    cfg_wdata
);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic signed [OBJ_W-1:0] cand_first_r, cand_first_nxt;
  logic signed [OBJ_W-1:0] cand_second_r, cand_second_nxt;
  logic [TAG_W-1:0]        cand_tag_r, cand_tag_nxt;
  logic [IDX_W-1:0]        k_r, k_nxt;
  logic [MASK_W-1:0]       mask_r, mask_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [OBJ_W-1:0] ideal_first_r, ideal_first_nxt;
  logic signed [OBJ_W-1:0] ideal_second_r, ideal_second_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [CNT_W-1:0]        nbr_cnt_r;
  logic [SCALE_W-1:0]      zw_scale_r;

  cmd_t                    in_cmd;
  logic [IDX_W-1:0]        in_index;
  logic [SLOT_W-1:0]       in_slot;
  logic [IDX_W-1:0]        in_neighbor;
  logic signed [OBJ_W-1:0] in_obj_first, in_obj_second;
  logic [WGT_W-1:0]        in_weight;
  logic [TAG_W-1:0]        in_tag;

  logic in_fire, out_free, last_slot, replace;
  logic [CNT_W-1:0] n_eff;

  logic                           nb_we, nb_re;
  logic [IDX_W+SLOT_W-1:0]        nb_waddr, nb_raddr;
  logic [IDX_W-1:0]               nb_rdata;
  logic                           ent_we, ent_re;
  logic [IDX_W-1:0]               ent_waddr;
  entry_t                         ent_wdata, ent_rdata;
  score_ctl_t                     score_ctl;

  assign in_cmd        = cmd_t'(in_tdata[1:0]);
  assign in_index      = in_tdata[9:2];
  assign in_slot       = in_tdata[13:10];
  assign in_neighbor   = in_tdata[21:14];
  assign in_obj_first  = in_tdata[53:22];
  assign in_obj_second = in_tdata[85:54];
  assign in_weight     = in_tdata[102:86];
  assign in_tag        = in_tdata[118:103];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign n_eff     = (nbr_cnt_r > CNT_W'(NEIGHBORS_MAX)) ? CNT_W'(NEIGHBORS_MAX) : nbr_cnt_r;
  assign last_slot = (CNT_W'(slot_r) == n_r - CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_cmd == CMD_OFFER) begin
          state_nxt = (n_eff == '0) ? S_DONE : S_NBR;
        end
      end
      S_NBR:  state_nxt = S_ENT;
      S_ENT:  state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_CMP;
      S_CMP:  state_nxt = last_slot ? S_DONE : S_ENT;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory control and datapath
  always_comb begin
    idx_nxt          = idx_r;
    slot_nxt         = slot_r;
    n_nxt            = n_r;
    cand_first_nxt   = cand_first_r;
    cand_second_nxt  = cand_second_r;
    cand_tag_nxt     = cand_tag_r;
    k_nxt            = k_r;
    mask_nxt         = mask_r;
    count_nxt        = count_r;
    ideal_first_nxt  = ideal_first_r;
    ideal_second_nxt = ideal_second_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_data_nxt     = out_data_r;

    nb_we     = 1'b0;
    nb_waddr  = {in_index, in_slot};
    nb_re     = (state_r == S_NBR) || (state_r == S_CMP);
    nb_raddr  = {idx_r, (state_r == S_CMP) ? slot_r + SLOT_W'(1) : slot_r};
    ent_we    = 1'b0;
    ent_waddr = in_index;
    ent_wdata = '{obj_first: in_obj_first, obj_second: in_obj_second, tag: in_tag,
                  weight: (in_weight > WEIGHT_ONE) ? WEIGHT_ONE : in_weight};
    ent_re    = (state_r == S_ENT);
    score_ctl = '{diff_en: state_r == S_DIFF, mul_en: state_r == S_MUL};

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_LOAD_ENTRY: ent_we = 1'b1;
            CMD_LOAD_NBR:   nb_we  = 1'b1;
            default: ;
          endcase
          if (in_cmd == CMD_OFFER) begin
            idx_nxt         = in_index;
            slot_nxt        = '0;
            n_nxt           = n_eff;
            cand_first_nxt  = in_obj_first;
            cand_second_nxt = in_obj_second;
            cand_tag_nxt    = in_tag;
            mask_nxt        = '0;
            count_nxt       = '0;
            if (in_obj_first < ideal_first_r) begin
              ideal_first_nxt = in_obj_first;
            end
            if (in_obj_second < ideal_second_r) begin
              ideal_second_nxt = in_obj_second;
            end
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {1'b0, ideal_second_r, ideal_first_r, CNT_W'(0), MASK_W'(0),
                             in_cmd};
          end
        end
      end
      S_ENT: k_nxt = nb_rdata;
      S_CMP: begin
        if (replace) begin
          ent_we    = 1'b1;
          ent_waddr = k_r;
          ent_wdata = '{obj_first: cand_first_r, obj_second: cand_second_r,
                        tag: cand_tag_r, weight: ent_rdata.weight};
          mask_nxt[slot_r] = 1'b1;
          count_nxt        = count_r + CNT_W'(1);
        end
        if (!last_slot) begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, ideal_second_r, ideal_first_r, count_r, mask_r, CMD_OFFER};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      ideal_first_r  <= IDEAL_RESET;
      ideal_second_r <= IDEAL_RESET;
      nbr_cnt_r      <= CNT_W'(NEIGHBORS_MAX);
      zw_scale_r     <= SCALE_W'(7);
      slot_r         <= '0;
      n_r            <= '0;
      mask_r         <= '0;
      count_r        <= '0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      ideal_first_r  <= ideal_first_nxt;
      ideal_second_r <= ideal_second_nxt;
      slot_r         <= slot_nxt;
      n_r            <= n_nxt;
      mask_r         <= mask_nxt;
      count_r        <= count_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_addr))
          CFG_NBR_COUNT: nbr_cnt_r  <= cfg_wdata[CNT_W-1:0];
          CFG_ZW_SCALE:  zw_scale_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    cand_first_r  <= cand_first_nxt;
    cand_second_r <= cand_second_nxt;
    cand_tag_r    <= cand_tag_nxt;
    k_r           <= k_nxt;
    out_data_r    <= out_data_nxt;
  end

  tnr_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NB_DEPTH)
  ) u_nbr_ram (
    .clk   (clk),
    .we    (nb_we),
    .waddr (nb_waddr),
    .wdata (in_neighbor),
    .re    (nb_re),
    .raddr (nb_raddr),
    .rdata (nb_rdata)
  );

  tnr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (POOL_DEPTH)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (nb_rdata),
    .rdata (ent_rdata)
  );

  tnr_score u_score (
    .clk          (clk),
    .ctl          (score_ctl),
    .ent          (ent_rdata),
    .cand_first   (cand_first_r),
    .cand_second  (cand_second_r),
    .ideal_first  (ideal_first_r),
    .ideal_second (ideal_second_r),
    .zw_scale     (zw_scale_r),
    .replace      (replace)
  );

  // walk never passes the configured neighbor count
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (CNT_W'(slot_r) < n_r))
    else $error("neighbor walk past slot limit");

  // entry memory written only by a load or by a replacement
  assert property (@(posedge clk) disable iff (!rst_n)
    ent_we |-> ((state_r == S_CMP) || (in_fire && in_cmd == CMD_LOAD_ENTRY)))
    else $error("unexpected entry memory write");

  // ideal point never rises outside reset
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (ideal_first_r <= $past(ideal_first_r)) &&
                     (ideal_second_r <= $past(ideal_second_r)))
    else $error("ideal point increased");

  // reported count matches the mask
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($countones(out_data_r[17:2]) == int'(out_data_r[22:18])))
    else $error("replaced count does not match mask");

endmodule

// ===== test/tnr_replacement_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tnr_replacement_checker
// watches the command, status and register ports of the neighbor replacement
// block, keeps a shadow pool, neighbor table and ideal point, predicts the
// status of every accepted command and compares it field by field
// ----------------------------------------------------------------------------
module tnr_replacement_checker
  import tnr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [SCALE_W-1:0]    cfg_wdata,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic                    pad;
    logic [TAG_W-1:0]        tag;
    logic [WGT_W-1:0]        weight;
    logic signed [OBJ_W-1:0] obj_second;
    logic signed [OBJ_W-1:0] obj_first;
    logic [IDX_W-1:0]        neighbor;
    logic [SLOT_W-1:0]       slot;
    logic [IDX_W-1:0]        index;
    cmd_t                    cmd;
  } pool_cmd_t;

  typedef struct packed {
    logic                    pad;
    logic signed [OBJ_W-1:0] ideal_second;
    logic signed [OBJ_W-1:0] ideal_first;
    logic [CNT_W-1:0]        count;
    logic [MASK_W-1:0]       mask;
    cmd_t                    done_cmd;
  } pool_status_t;

  logic signed [OBJ_W-1:0] pool_first  [POOL_DEPTH];
  logic signed [OBJ_W-1:0] pool_second [POOL_DEPTH];
  logic [TAG_W-1:0]        pool_tag    [POOL_DEPTH];
  logic [WGT_W-1:0]        pool_weight [POOL_DEPTH];
  logic [IDX_W-1:0]        nbr_table   [POOL_DEPTH][NEIGHBORS_MAX];
  logic signed [OBJ_W-1:0] ideal_first;
  logic signed [OBJ_W-1:0] ideal_second;
  logic [4:0]              walk_limit;
  logic [SCALE_W-1:0]      zw_scale;

  pool_status_t expected_status_q[$];
  int           fail_count = 0;
  int           pending_status = 0;

  assign mismatches  = fail_count;
  assign outstanding = pending_status;

  task automatic report_mismatch(input string msg);
    $display("[%0t] replacement check: %s", $time, msg);
    fail_count++;
  endtask

  function automatic longint weighted_gap(input logic signed [OBJ_W-1:0] value,
                                          input logic signed [OBJ_W-1:0] ideal,
                                          input logic [WGT_W-1:0] wgt);
    longint diff;
    longint factor;
    diff = longint'(value) - longint'(ideal);
    if (diff < 0) begin
      diff = -diff;
    end
    factor = (wgt == '0) ? longint'(zw_scale) : longint'(wgt);
    return diff * factor;
  endfunction

  function automatic longint tcheby_score(input logic signed [OBJ_W-1:0] o1,
                                          input logic signed [OBJ_W-1:0] o2,
                                          input logic [WGT_W-1:0] w1);
    longint a;
    longint b;
    a = weighted_gap(o1, ideal_first, w1);
    b = weighted_gap(o2, ideal_second, WGT_W'(WEIGHT_ONE - w1));
    return (a > b) ? a : b;
  endfunction

  function automatic pool_status_t predict_replacement(input pool_cmd_t it);
    pool_status_t st;
    int           walk;
    logic [IDX_W-1:0] k;
    longint       stored;
    longint       cand;
    st = '0;
    st.done_cmd = it.cmd;
    case (it.cmd)
      CMD_LOAD_ENTRY: begin
        pool_first[it.index]  = it.obj_first;
        pool_second[it.index] = it.obj_second;
        pool_tag[it.index]    = it.tag;
        pool_weight[it.index] = (it.weight > WEIGHT_ONE) ? WEIGHT_ONE : it.weight;
      end
      CMD_LOAD_NBR: begin
        nbr_table[it.index][it.slot] = it.neighbor;
      end
      CMD_OFFER: begin
        if (it.obj_first < ideal_first) begin
          ideal_first = it.obj_first;
        end
        if (it.obj_second < ideal_second) begin
          ideal_second = it.obj_second;
        end
        walk = (walk_limit > NEIGHBORS_MAX) ? NEIGHBORS_MAX : int'(walk_limit);
        for (int i = 0; i < walk; i++) begin
          k = nbr_table[it.index][i];
          stored = tcheby_score(pool_first[k], pool_second[k], pool_weight[k]);
          cand = tcheby_score(it.obj_first, it.obj_second, pool_weight[k]);
          if (cand < stored) begin
            pool_first[k]  = it.obj_first;
            pool_second[k] = it.obj_second;
            pool_tag[k]    = it.tag;
            st.mask[i]     = 1'b1;
            st.count       = st.count + 1'b1;
          end
        end
      end
      default: ;
    endcase
    st.ideal_first  = ideal_first;
    st.ideal_second = ideal_second;
    return st;
  endfunction

  always @(posedge clk) begin
    pool_status_t got;
    pool_status_t want;
    if (!rst_n) begin
      for (int i = 0; i < POOL_DEPTH; i++) begin
        pool_first[i]  = '0;
        pool_second[i] = '0;
        pool_tag[i]    = '0;
        pool_weight[i] = '0;
        for (int j = 0; j < NEIGHBORS_MAX; j++) begin
          nbr_table[i][j] = '0;
        end
      end
      ideal_first  = IDEAL_RESET;
      ideal_second = IDEAL_RESET;
      walk_limit   = 5'd16;
      zw_scale     = 16'd7;
      expected_status_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_NBR_COUNT) begin
          walk_limit = cfg_wdata[4:0];
        end else begin
          zw_scale = cfg_wdata;
        end
      end
      if (out_tvalid && out_tready) begin
        got = pool_status_t'(out_tdata);
        if (expected_status_q.size() == 0) begin
          report_mismatch($sformatf("status %h with no transaction pending", out_tdata));
        end else begin
          want = expected_status_q.pop_front();
          if (got.done_cmd != want.done_cmd) begin
            report_mismatch($sformatf("done_cmd got %0d expected %0d",
                                      got.done_cmd, want.done_cmd));
          end
          if (got.mask != want.mask) begin
            report_mismatch($sformatf("replaced_mask got %h expected %h",
                                      got.mask, want.mask));
          end
          if (got.count != want.count) begin
            report_mismatch($sformatf("replaced_count got %0d expected %0d",
                                      got.count, want.count));
          end
          if (got.ideal_first != want.ideal_first) begin
            report_mismatch($sformatf("ideal_first got %h expected %h",
                                      got.ideal_first, want.ideal_first));
          end
          if (got.ideal_second != want.ideal_second) begin
            report_mismatch($sformatf("ideal_second got %h expected %h",
                                      got.ideal_second, want.ideal_second));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_status_q.insert(expected_status_q.size(),
                                 predict_replacement(pool_cmd_t'(in_tdata)));
      end
    end
    pending_status <= expected_status_q.size();
  end

endmodule

// ===== test/tb_tchebycheff_neighbor_replacement.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tchebycheff_neighbor_replacement
// drives load, offer and unused commands into the neighbor replacement block
// under several register settings, with bursty input and a stalling output;
// the checker beside the block predicts every status and counts mismatches
// ----------------------------------------------------------------------------
module tb_tchebycheff_neighbor_replacement;
  import tnr_pkg::*;

  localparam int IDLE_LIMIT  = 1000;
  localparam int HOT_SUBPROB = 8;
  localparam int PHASE_ITEMS = 90;

  typedef enum int {
    RX_OPEN,
    RX_SPARSE,
    RX_PERIODIC,
    RX_COIN
  } rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic                  cfg_addr = 1'b0;
  logic [SCALE_W-1:0]    cfg_wdata = '0;
  int                    mismatches;
  int                    outstanding;

  // shadow of what has been loaded, so an offer never walks an unwritten slot
  bit               entry_loaded [POOL_DEPTH];
  bit               slot_loaded  [POOL_DEPTH][NEIGHBORS_MAX];
  logic [IDX_W-1:0] slot_target  [POOL_DEPTH][NEIGHBORS_MAX];
  int               loaded_q[$];
  int               walk_len = NEIGHBORS_MAX;
  int               burst_left = 0;
  rx_mode_t         rx_mode = RX_OPEN;
  int               rx_tick = 0;

  always #5 clk = ~clk;

  tchebycheff_neighbor_replacement i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  tnr_replacement_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // receiver stall pattern, switching periodically to a randomly drawn mode
  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 97 == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_OPEN:     out_tready <= 1'b1;
      RX_SPARSE:   out_tready <= ($urandom_range(0, 9) < 3);
      RX_PERIODIC: out_tready <= (rx_tick % 4 == 0);
      default:     out_tready <= $urandom_range(0, 1);
    endcase
  end

  function automatic logic signed [OBJ_W-1:0] rand_obj();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      return OBJ_W'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
    end else if (pick < 95) begin
      return OBJ_W'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
    end
    return OBJ_W'($urandom);
  endfunction

  function automatic logic [WGT_W-1:0] rand_weight();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      return '0;
    end else if (pick < 20) begin
      return WEIGHT_ONE;
    end else if (pick < 25) begin
      return WGT_W'($urandom_range(65537, 131071));
    end
    return WGT_W'($urandom_range(1, 65535));
  endfunction

  task automatic send_item(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                           input logic [SLOT_W-1:0] slot, input logic [IDX_W-1:0] nb,
                           input logic signed [OBJ_W-1:0] o1,
                           input logic signed [OBJ_W-1:0] o2,
                           input logic [WGT_W-1:0] wgt, input logic [TAG_W-1:0] tag);
    int gap;
    case (cmd)
      CMD_LOAD_ENTRY: begin
        if (!entry_loaded[idx]) begin
          entry_loaded[idx] = 1'b1;
          loaded_q.insert(loaded_q.size(), int'(idx));
        end
      end
      CMD_LOAD_NBR: begin
        slot_loaded[idx][slot] = 1'b1;
        slot_target[idx][slot] = nb;
      end
      default: ;
    endcase
    in_tdata  <= {1'b0, tag, wgt, o2, o1, nb, slot, idx, cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic load_entry(input logic [IDX_W-1:0] idx);
    send_item(CMD_LOAD_ENTRY, idx, SLOT_W'($urandom), IDX_W'($urandom), rand_obj(),
              rand_obj(), rand_weight(), TAG_W'($urandom));
  endtask

  // make sure every slot the offer walks points at a loaded entry
  task automatic prep_walk(input logic [IDX_W-1:0] sp);
    logic [IDX_W-1:0] nb;
    for (int i = 0; i < walk_len; i++) begin
      if (!slot_loaded[sp][i]) begin
        if ($urandom_range(0, 3) == 0 || loaded_q.size() == 0) begin
          nb = IDX_W'($urandom);
        end else begin
          nb = IDX_W'(loaded_q[$urandom_range(0, loaded_q.size() - 1)]);
        end
        send_item(CMD_LOAD_NBR, sp, SLOT_W'(i), nb, rand_obj(), rand_obj(),
                  rand_weight(), TAG_W'($urandom));
      end
      if (!entry_loaded[slot_target[sp][i]]) begin
        load_entry(slot_target[sp][i]);
      end
    end
  endtask

  task automatic offer(input logic [IDX_W-1:0] sp, input logic signed [OBJ_W-1:0] o1,
                       input logic signed [OBJ_W-1:0] o2);
    prep_walk(sp);
    send_item(CMD_OFFER, sp, SLOT_W'($urandom), IDX_W'($urandom), o1, o2,
              rand_weight(), TAG_W'($urandom));
  endtask

  task automatic random_item();
    int pick;
    logic [IDX_W-1:0] sp;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) begin
      sp = IDX_W'($urandom);
    end else begin
      sp = IDX_W'($urandom_range(0, HOT_SUBPROB - 1));
    end
    if (pick < 12) begin
      load_entry(IDX_W'($urandom));
    end else if (pick < 22) begin
      send_item(CMD_LOAD_NBR, sp, SLOT_W'($urandom), IDX_W'($urandom), rand_obj(),
                rand_obj(), rand_weight(), TAG_W'($urandom));
    end else if (pick < 26) begin
      send_item(CMD_UNUSED, IDX_W'($urandom), SLOT_W'($urandom), IDX_W'($urandom),
                OBJ_W'($urandom), OBJ_W'($urandom), WGT_W'($urandom), TAG_W'($urandom));
    end else begin
      offer(sp, rand_obj(), rand_obj());
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_config(input int nbr_cnt, input logic [SCALE_W-1:0] scale);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_NBR_COUNT;
    cfg_wdata <= SCALE_W'(nbr_cnt);
    @(posedge clk);
    cfg_addr  <= CFG_ZW_SCALE;
    cfg_wdata <= scale;
    @(posedge clk);
    cfg_we <= 1'b0;
    walk_len = (nbr_cnt > NEIGHBORS_MAX) ? NEIGHBORS_MAX : nbr_cnt;
    burst_left = 0;
  endtask

  task automatic run_phase();
    repeat (PHASE_ITEMS) random_item();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of the entry fields, saturating weight, last slot, unused command
    send_item(CMD_LOAD_ENTRY, 8'd0, 4'hF, 8'hFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
              17'd0, 16'hFFFF);
    send_item(CMD_LOAD_ENTRY, 8'd255, 4'h0, 8'h00, 32'sh8000_0000, 32'sh7FFF_FFFF,
              WEIGHT_ONE, 16'h0000);
    send_item(CMD_LOAD_ENTRY, 8'd1, 4'h5, 8'h5A, 32'sd0, 32'sd0, 17'h1FFFF, 16'h1234);
    send_item(CMD_LOAD_ENTRY, 8'd2, 4'hA, 8'hA5, 32'sh0001_0000, -32'sh0002_0000,
              17'd32768, 16'hA5A5);
    send_item(CMD_LOAD_NBR, 8'd255, 4'hF, 8'd255, '0, '0, '0, '0);
    send_item(CMD_UNUSED, 8'hFF, 4'hF, 8'hFF, '1, '1, '1, '1);
    // offers: equal to the ideal point, repeated candidate, zero second weight
    offer(8'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    offer(8'd0, 32'sh0003_0000, 32'sh0001_0000);
    offer(8'd0, 32'sh0003_0000, 32'sh0001_0000);
    offer(8'd255, 32'sh0000_8000, -32'sh0000_8000);

    run_phase();
    set_config(1, 16'h0000);
    run_phase();
    set_config(0, 16'hFFFF);
    run_phase();
    set_config(31, SCALE_W'($urandom));
    run_phase();
    set_config(16, 16'h0001);
    run_phase();
    set_config($urandom_range(2, 15), SCALE_W'($urandom_range(1, 65534)));
    run_phase();

    // most negative and most positive objectives once the ideal point has settled
    set_config(16, 16'd7);
    offer(8'd0, 32'sh8000_0000, 32'sh8000_0000);
    offer(8'd1, 32'sh7FFF_FFFF, 32'sh8000_0000);
    offer(8'd2, 32'sh8000_0000, 32'sh7FFF_FFFF);
    repeat (20) random_item();

    drain();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

endmodule
